FILE: rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the multichannel moving average filter.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int unsigned NUM_FIELDS      = 8;
  localparam int unsigned SAMPLE_W        = 12;
  localparam int unsigned CHANNELS_DEF    = 8;
  localparam int unsigned WINDOW_DEF      = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_0;
    logic [SAMPLE_W-1:0] average_1;
    logic [SAMPLE_W-1:0] average_2;
    logic [SAMPLE_W-1:0] average_3;
    logic [SAMPLE_W-1:0] average_4;
    logic [SAMPLE_W-1:0] average_5;
    logic [SAMPLE_W-1:0] average_6;
    logic [SAMPLE_W-1:0] average_7;
  } out_item_t;

  // per-stage load strobes shared by all lanes
  typedef struct packed {
    logic load_ring;
    logic primed;
    logic load_sum;
    logic load_mult;
  } stage_en_t;

endpackage

FILE: rtl/mma_lane.sv
// ----------------------------------------------------------------------------
// mma_lane
// One channel: sample ring, running sum and divide-by-window by reciprocal.
// ----------------------------------------------------------------------------
module mma_lane #(
  parameter int unsigned WINDOW      = mma_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mma_pkg::stage_en_t           ctl,
  input  logic [$clog2(WINDOW)-1:0]    pos,
  input  logic [mma_pkg::SAMPLE_W-1:0] sample,
  output logic [mma_pkg::SAMPLE_W-1:0] average
);
  import mma_pkg::*;

  localparam int unsigned POS_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W  = $clog2(WINDOW * ((2 ** SAMPLE_BITS) - 1) + 1);
  localparam int unsigned SHIFT  = SUM_W + POS_W;
  localparam int unsigned MULT_W = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + MULT_W;
  localparam longint unsigned MULT =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  logic [SAMPLE_BITS-1:0] ring [WINDOW];
  logic [SAMPLE_BITS-1:0] oldest;
  logic [SAMPLE_BITS-1:0] fresh;
  logic [SUM_W-1:0]       sum;
  logic [PROD_W-1:0]      prod;

  // read-before-write; slots not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (ctl.load_ring) begin
      ring[pos[POS_W-1:0]] <= SAMPLE_BITS'(sample);
      oldest               <= ctl.primed ? ring[pos[POS_W-1:0]] : '0;
      fresh                <= SAMPLE_BITS'(sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.load_sum) begin
      sum <= sum - SUM_W'(oldest) + SUM_W'(fresh);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_mult) begin
      prod <= PROD_W'(sum) * PROD_W'(MULT_W'(MULT));
    end
  end

  assign average = SAMPLE_W'(prod >> SHIFT);

endmodule

FILE: rtl/multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Eight-lane moving average over the last WINDOW frames of ADC samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample / sample_valid / sample_ready carry one frame of eight samples per
//   item. average / average_valid / average_ready carry one result item per
//   frame: each channel's sum over the last WINDOW frames divided by WINDOW,
//   truncated. Channels at or above CHANNELS read as zero.
//   Four register stages: ring read, sum update, reciprocal multiply, output
//   register, in that order. One item per cycle is sustained while the
//   receiver keeps average_ready high; each lane's running-sum register feeds
//   back on itself directly, so consecutive frames flow back to back.
//   A stalled receiver holds the output register; upstream stages keep
//   accepting until every stage is full, so up to four items are in flight.
//   Synchronous reset clears the sums, the ring position and the pipeline;
//   ring slots not written since reset read as zero, so the first WINDOW-1
//   results average in zeros. No clearing pass is needed.
// ----------------------------------------------------------------------------
module multichannel_moving_average #(
  parameter int unsigned CHANNELS    = mma_pkg::CHANNELS_DEF,
  parameter int unsigned WINDOW      = mma_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  mma_pkg::in_item_t  sample,
  output logic               average_valid,
  input  logic               average_ready,
  output mma_pkg::out_item_t average
);
  import mma_pkg::*;

  localparam int unsigned POS_W = $clog2(WINDOW);

  logic             v_ring;
  logic             v_sum;
  logic             v_mult;
  logic             en_out;
  logic             en_mult;
  logic             en_sum;
  logic             en_ring;
  logic             accept;
  logic [POS_W-1:0] pos;
  logic             primed;
  stage_en_t        ctl;

  logic [SAMPLE_W-1:0] lane_in  [NUM_FIELDS];
  logic [SAMPLE_W-1:0] lane_out [NUM_FIELDS];

  assign en_out       = !average_valid || average_ready;
  assign en_mult      = !v_mult || en_out;
  assign en_sum       = !v_sum || en_mult;
  assign en_ring      = !v_ring || en_sum;
  assign sample_ready = en_ring;
  assign accept       = sample_valid && en_ring;

  assign ctl.load_ring = accept;
  assign ctl.primed    = primed;
  assign ctl.load_sum  = v_ring && en_sum;
  assign ctl.load_mult = v_sum && en_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_ring        <= 1'b0;
      v_sum         <= 1'b0;
      v_mult        <= 1'b0;
      average_valid <= 1'b0;
    end else begin
      if (en_ring) v_ring <= sample_valid;
      if (en_sum) v_sum <= v_ring;
      if (en_mult) v_mult <= v_sum;
      if (en_out) average_valid <= v_mult;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      primed <= 1'b0;
    end else if (accept) begin
      if (pos == POS_W'(WINDOW - 1)) begin
        pos    <= '0;
        primed <= 1'b1;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  assign lane_in[0] = sample.sample_0;
  assign lane_in[1] = sample.sample_1;
  assign lane_in[2] = sample.sample_2;
  assign lane_in[3] = sample.sample_3;
  assign lane_in[4] = sample.sample_4;
  assign lane_in[5] = sample.sample_5;
  assign lane_in[6] = sample.sample_6;
  assign lane_in[7] = sample.sample_7;

  for (genvar c = 0; c < NUM_FIELDS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      mma_lane #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .pos     (pos),
        .sample  (lane_in[c]),
        .average (lane_out[c])
      );
    end else begin : g_off
      assign lane_out[c] = '0;
    end
  end

  // merge lanes into the output item
  always_ff @(posedge clk) begin
    if (v_mult && en_out) begin
      average.average_0 <= lane_out[0];
      average.average_1 <= lane_out[1];
      average.average_2 <= lane_out[2];
      average.average_3 <= lane_out[3];
      average.average_4 <= lane_out[4];
      average.average_5 <= lane_out[5];
      average.average_6 <= lane_out[6];
      average.average_7 <= lane_out[7];
    end
  end

endmodule

FILE: rtl/mma_checker.sv
// ----------------------------------------------------------------------------
// mma_checker
// Port-level assertions on the moving average filter, bound to the top level.
// ----------------------------------------------------------------------------
module mma_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_ready,
  input logic               average_valid,
  input logic               average_ready,
  input mma_pkg::out_item_t average
);
  import mma_pkg::*;

  localparam int unsigned DEPTH = 4;

  logic [2:0] inflight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = sample_valid && sample_ready;
  assign out_acc = average_valid && average_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !average_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    average_valid && !average_ready |=> average_valid && $stable(average))
    else $error("stalled result changed or dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    average_valid |-> inflight != 3'd0)
    else $error("result with no item in flight");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'(DEPTH))
    else $error("more items in flight than pipeline stages");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !average_valid |-> sample_ready)
    else $error("input stalled while output register is empty");

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_valid  (sample_valid),
  .sample_ready  (sample_ready),
  .average_valid (average_valid),
  .average_ready (average_ready),
  .average       (average)
);
